// ----- hdl/crc16_checked_frame_receiver_core_macros.svh -----
// Assertion macros for the checker file of this block.
`ifndef CRC16_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH
`define CRC16_CHECKED_FRAME_RECEIVER_CORE_MACROS_SVH

// Concurrent assertion on the block clock, switched off while reset is held.
`define CRCFR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("crcfr: assertion failed");

// Antecedent in one cycle implies the consequent in the next one.
`define CRCFR_ASSERT_NEXT(lbl, ante, cons) \
  `CRCFR_ASSERT(lbl, (ante) |=> (cons))

`endif

// ----- hdl/crcfr_pkg.sv -----
package crcfr_pkg;

  localparam int unsigned MAX_FRAME_DEF = 64;
  localparam int unsigned LEN_W = 7;
  localparam int unsigned NUM_BANKS = 2;

  localparam logic [LEN_W-1:0] FRAME_LEN_RST = 7'd8;
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 7'd2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_IDLE = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e  req_type;
    logic [7:0] rx_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
  } out_res_t;

  // Status of the frame queue; the bank bits select the half of the frame store.
  typedef struct packed {
    logic empty;
    logic full;
    logic wr_bank;
    logic rd_bank;
  } q_stat_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/crcfr_frame_ram.sv -----
module crcfr_frame_ram import crcfr_pkg::*; #(
  parameter int unsigned AW = 7
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [2**AW];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read data holds between reads, so a stalled result stays put.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/crcfr_desc_fifo.sv -----
module crcfr_desc_fifo import crcfr_pkg::*; #(
  parameter int unsigned DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] head_o,
  output q_stat_t       stat_o
);

  localparam int unsigned CntW = $clog2(NUM_BANKS + 1);

  logic [DW-1:0]   len_q [NUM_BANKS];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q ^ push_i;
    rptr_d = rptr_q ^ pop_i;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      len_q[wptr_q] <= push_data_i;
    end
  end

  assign head_o         = len_q[rptr_q];
  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.full    = (cnt_q == CntW'(NUM_BANKS));
  assign stat_o.wr_bank = wptr_q;
  assign stat_o.rd_bank = rptr_q;

endmodule

// ----- hdl/crcfr_front.sv -----
module crcfr_front import crcfr_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF,
  localparam int unsigned CntW = $clog2(MAX_FRAME + 1),
  localparam int unsigned IdxW = $clog2(MAX_FRAME)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_req_t          in_req_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output logic [CntW-1:0]  push_len_o,
  output logic             wr_en_o,
  output logic [IdxW:0]    wr_addr_o,
  output logic [7:0]       wr_data_o
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FRAME);

  logic [LEN_W-1:0] len_q, len_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      crc_q, crc_d;
  logic             disc_q, disc_d;
  logic [7:0]       prev_q, prev_d;

  logic [LEN_W-1:0] len_act;
  logic [LEN_W-1:0] cnt_ext;
  logic             accept;
  logic             take_byte;
  logic             crc_upd;
  logic             frame_end;
  logic             good;
  logic             cfg_wr;

  always_comb begin
    if (len_q < MIN_FRAME_LEN) begin
      len_act = MIN_FRAME_LEN;
    end else if (len_q > MaxLen) begin
      len_act = MaxLen;
    end else begin
      len_act = len_q;
    end
  end

  assign in_stall_o  = q_stat_i.full;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign accept    = in_valid_i && !in_stall_o;
  assign take_byte = accept && (in_req_i.req_type == REQ_BYTE) && !disc_q;
  assign cnt_ext   = LEN_W'(cnt_q);
  assign crc_upd   = (cnt_ext + LEN_W'(2)) < len_act;
  assign frame_end = (cnt_ext + LEN_W'(1)) == len_act;
  // The two CRC bytes are the one before and the one now arriving.
  assign good      = (prev_q == crc_q[7:0]) && (in_req_i.rx_byte == crc_q[15:8]);

  assign wr_en_o    = take_byte;
  assign wr_addr_o  = {q_stat_i.wr_bank, cnt_q[IdxW-1:0]};
  assign wr_data_o  = in_req_i.rx_byte;
  assign push_o     = take_byte && frame_end && good;
  assign push_len_o = CntW'(len_act);

  always_comb begin
    len_d  = len_q;
    cnt_d  = cnt_q;
    crc_d  = crc_q;
    disc_d = disc_q;
    prev_d = prev_q;
    if (cfg_wr) begin
      len_d = cfg_data_i;
      cnt_d = '0;
      crc_d = CRC_INIT;
    end else if (accept && (in_req_i.req_type == REQ_IDLE)) begin
      disc_d = 1'b0;
    end else if (take_byte) begin
      prev_d = in_req_i.rx_byte;
      if (crc_upd) begin
        crc_d = crc_byte(crc_q, in_req_i.rx_byte);
      end
      if (frame_end) begin
        cnt_d = '0;
        crc_d = CRC_INIT;
        if (!good) begin
          disc_d = 1'b1;
        end
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= FRAME_LEN_RST;
      cnt_q  <= '0;
      crc_q  <= CRC_INIT;
      disc_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      cnt_q  <= cnt_d;
      crc_q  <= crc_d;
      disc_q <= disc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
  end

endmodule

// ----- hdl/crcfr_back.sv -----
module crcfr_back import crcfr_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF,
  localparam int unsigned CntW = $clog2(MAX_FRAME + 1),
  localparam int unsigned IdxW = $clog2(MAX_FRAME)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_stat_t         q_stat_i,
  input  logic [CntW-1:0] head_len_i,
  output logic            pop_o,
  output logic            rd_en_o,
  output logic [IdxW:0]   rd_addr_o,
  input  logic [7:0]      rd_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_res_t        out_res_o
);

  typedef enum logic {
    IdleSt,
    ShowSt
  } state_e;

  state_e          state_q;
  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  logic [CntW-1:0] len_q;
  logic            last_q;

  logic            start;
  logic            advance;
  logic            finish;
  logic [IdxW-1:0] rd_idx;
  logic [CntW-1:0] nlen;
  logic            nlast;

  assign start   = (state_q == IdleSt) && !q_stat_i.empty;
  assign advance = (state_q == ShowSt) && !out_stall_i && !last_q;
  assign finish  = (state_q == ShowSt) && !out_stall_i && last_q;

  assign rd_idx = start ? '0 : idx_q + IdxW'(1);
  assign nlen   = start ? head_len_i : len_q;
  assign nlast  = (CntW'(rd_idx) + CntW'(1)) == nlen;

  assign rd_en_o   = start || advance;
  assign rd_addr_o = {q_stat_i.rd_bank, rd_idx};
  // The bank is released only when its last byte has been taken.
  assign pop_o     = finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IdleSt;
      valid_q <= 1'b0;
      idx_q   <= '0;
      len_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        IdleSt: begin
          if (start) begin
            state_q <= ShowSt;
            valid_q <= 1'b1;
            idx_q   <= rd_idx;
            len_q   <= nlen;
            last_q  <= nlast;
          end
        end
        ShowSt: begin
          if (finish) begin
            state_q <= IdleSt;
            valid_q <= 1'b0;
          end else if (advance) begin
            idx_q  <= rd_idx;
            last_q <= nlast;
          end
        end
        default: begin
          state_q <= IdleSt;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o             = valid_q;
  assign out_res_o.frame_byte    = rd_data_i;
  assign out_res_o.last_of_frame = last_q;

endmodule

// ----- hdl/crc16_checked_frame_receiver_core.sv -----
// CRC-16 checked fixed-length frame receiver.
// Input channel (in_valid_i / in_stall_o / in_req_i): one request per received
// byte or per receiver idle event. A frame of frame_length bytes is checked
// against a reflected CRC-16 over all but its last two bytes; a good frame is
// replayed on the output channel (out_valid_o / out_stall_i / out_res_o), one
// byte per cycle while out_stall_i is low, last byte marked. When the output
// side is free, the first byte is valid once the queue registers the frame and
// the replay side loads it; out_valid_o drops between two replayed frames.
// A bad frame gives nothing, and bytes are dropped until an idle event.
// The frame store has two banks: one gathers while the other replays. The input
// stalls only while both banks hold good frames not yet fully replayed, so it
// follows the drain rate of the output when the output side stalls.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes
// frame_length at any cycle; the block must be written only while idle, which
// it does not enforce. A write drops the partial frame. Reset sets frame_length
// to 8, clears partial frame, queue and discard state; no clearing pass needed.
module crc16_checked_frame_receiver_core import crcfr_pkg::*; #(
  parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_req_t          in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_res_t         out_res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LEN_W-1:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
  localparam int unsigned IdxW = $clog2(MAX_FRAME);

  q_stat_t         q_stat;
  logic            push;
  logic [CntW-1:0] push_len;
  logic            pop;
  logic [CntW-1:0] head_len;
  logic            wr_en;
  logic [IdxW:0]   wr_addr;
  logic [7:0]      wr_data;
  logic            rd_en;
  logic [IdxW:0]   rd_addr;
  logic [7:0]      rd_data;

  crcfr_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_len_o  (push_len),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  crcfr_desc_fifo #(
    .DW (CntW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_len),
    .pop_i       (pop),
    .head_o      (head_len),
    .stat_o      (q_stat)
  );

  crcfr_frame_ram #(
    .AW (IdxW + 1)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  crcfr_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_len_i  (head_len),
    .pop_o       (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

// ----- hdl/crcfr_checker.sv -----
`include "crc16_checked_frame_receiver_core_macros.svh"

module crcfr_checker import crcfr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input in_req_t          in_req_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_res_t         out_res_o
);

  logic in_take;
  logic out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // A stalled result holds.
  `CRCFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_res_o))

  // Both banks can only fill up on the last byte of a frame.
  `CRCFR_ASSERT(a_stall_rise, $rose(in_stall_o) |-> $past(in_take && in_req_i.req_type == REQ_BYTE))

  // A bank is freed only when the final byte of a frame is taken.
  `CRCFR_ASSERT(a_stall_fall, $fell(in_stall_o) |-> $past(out_take && out_res_o.last_of_frame))

  // With both banks full, a frame is always being replayed.
  `CRCFR_ASSERT(a_stall_replay, in_stall_o |-> out_valid_o)

endmodule

bind crc16_checked_frame_receiver_core crcfr_checker u_checker (.*);
